[rtl/core/iso2022jp_to_eucjp_converter_assert.svh]
// Assertion macros for the ISO-2022-JP to EUC-JP converter.
`ifndef ISO2022JP_TO_EUCJP_CONVERTER_ASSERT_SVH
`define ISO2022JP_TO_EUCJP_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define I2E_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("converter assertion failed");
// next-cycle implication, checked out of reset
`define I2E_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("converter assertion failed");
`else
`define I2E_ASSERT_IMP(lbl, ante, cons)
`define I2E_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/i2e_pkg.sv]
// Shared types and constants for the ISO-2022-JP to EUC-JP converter.
package i2e_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_SO     = 8'h0e;
    localparam logic [7:0] CH_SI     = 8'h0f;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_J      = 8'h4a;
    localparam logic [7:0] HIGH_BIT  = 8'h80;
    localparam logic [7:0] SS2       = 8'h8e;
    localparam logic [7:0] SS3       = 8'h8f;

    typedef enum logic [1:0] {
        MODE_ASCII = 2'd0,
        MODE_KANJI = 2'd1,
        MODE_AUX   = 2'd2,
        MODE_KANA  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ESC_IDLE   = 3'd0,
        ESC_SEEN   = 3'd1,
        ESC_DOLLAR = 3'd2,
        ESC_DPAREN = 3'd3,
        ESC_PAREN  = 3'd4
    } esc_t;

    // up to three output words produced by one input word
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[rtl/core/i2e_front.sv]
// Front end: takes input words, tracks mode/escape state, builds output commands.
module i2e_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    in_byte,
    input  i2e_pkg::q_stat_t q_stat,
    output logic          push,
    output i2e_pkg::cmd_t cmd
);
    import i2e_pkg::*;

    mode_t      mode_reg, mode_next;
    esc_t       esc_reg, esc_next;
    logic       due_reg, due_next;
    logic       accept;
    logic       matched;
    logic [1:0] n;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign push     = accept && (cmd.count != 2'd0);

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        due_next  = due_reg;
        cmd       = '0;
        n         = 2'd0;
        matched   = 1'b0;

        if (esc_reg != ESC_IDLE)
        begin
            matched = 1'b1;
            priority if (esc_reg == ESC_SEEN && in_byte == CH_DOLLAR)
                esc_next = ESC_DOLLAR;
            else if (esc_reg == ESC_SEEN && in_byte == CH_LPAREN)
                esc_next = ESC_PAREN;
            else if (esc_reg == ESC_DOLLAR && (in_byte == CH_AT || in_byte == CH_B))
            begin
                mode_next = MODE_KANJI;
                esc_next  = ESC_IDLE;
            end
            else if (esc_reg == ESC_DOLLAR && in_byte == CH_LPAREN)
                esc_next = ESC_DPAREN;
            else if (esc_reg == ESC_DPAREN && in_byte == CH_D)
            begin
                mode_next = MODE_AUX;
                esc_next  = ESC_IDLE;
            end
            else if (esc_reg == ESC_PAREN && (in_byte == CH_B || in_byte == CH_J))
            begin
                mode_next = MODE_ASCII;
                esc_next  = ESC_IDLE;
            end
            else if (esc_reg == ESC_PAREN && in_byte == CH_I)
            begin
                mode_next = MODE_KANA;
                esc_next  = ESC_IDLE;
            end
            else
            begin
                // broken escape: flush held bytes, then treat word as ASCII
                matched   = 1'b0;
                mode_next = MODE_ASCII;
                esc_next  = ESC_IDLE;
                if (esc_reg == ESC_DOLLAR || esc_reg == ESC_DPAREN)
                begin
                    cmd.data[n] = CH_DOLLAR;
                    n = n + 2'd1;
                end
                if (esc_reg == ESC_DPAREN || esc_reg == ESC_PAREN)
                begin
                    cmd.data[n] = CH_LPAREN;
                    n = n + 2'd1;
                end
            end
        end

        if (!matched)
        begin
            priority if (in_byte == CH_NUL)
            begin
                cmd.data[n] = CH_NUL;
                cmd.last    = 1'b1;
                n = n + 2'd1;
                mode_next = MODE_ASCII;
                due_next  = 1'b0;
            end
            else if (due_reg)
            begin
                cmd.data[n] = in_byte | HIGH_BIT;
                n = n + 2'd1;
                due_next = 1'b0;
            end
            else if (in_byte == CH_ESC)
                esc_next = ESC_SEEN;
            else if (in_byte == CH_SO)
                mode_next = MODE_KANA;
            else if (in_byte == CH_SI)
                mode_next = MODE_ASCII;
            else
            begin
                unique case (mode_next)
                    MODE_ASCII:
                    begin
                        cmd.data[n] = in_byte;
                        n = n + 2'd1;
                    end
                    MODE_KANJI:
                    begin
                        cmd.data[n] = in_byte | HIGH_BIT;
                        n = n + 2'd1;
                        due_next = 1'b1;
                    end
                    MODE_AUX:
                    begin
                        cmd.data[n] = SS3;
                        n = n + 2'd1;
                        cmd.data[n] = in_byte | HIGH_BIT;
                        n = n + 2'd1;
                        due_next = 1'b1;
                    end
                    MODE_KANA:
                    begin
                        cmd.data[n] = SS2;
                        n = n + 2'd1;
                        cmd.data[n] = in_byte | HIGH_BIT;
                        n = n + 2'd1;
                    end
                    default:
                    begin
                        cmd.data[n] = in_byte;
                        n = n + 2'd1;
                    end
                endcase
            end
        end
        cmd.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ASCII;
            esc_reg  <= ESC_IDLE;
            due_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            due_reg  <= due_next;
        end
    end

endmodule

[rtl/core/i2e_queue.sv]
// Small command FIFO between front and back ends.
module i2e_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  i2e_pkg::cmd_t    cmd_in,
    input  logic             pop,
    output i2e_pkg::cmd_t    head,
    output i2e_pkg::q_stat_t q_stat
);
    import i2e_pkg::*;

    cmd_t             entry_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0] cnt_reg, cnt_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == QCntW'(QDepth));
    assign q_stat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/core/i2e_back.sv]
// Back end: walks each queued command one output word per cycle while out_stall is low.
module i2e_back (
    input  logic             clk,
    input  logic             rst_n,
    input  i2e_pkg::cmd_t    head,
    input  i2e_pkg::q_stat_t q_stat,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             last
);
    import i2e_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       load;
    logic       take;
    logic       final_word;

    assign load       = !out_valid_reg || !out_stall;
    assign take       = load && !q_stat.empty;
    assign final_word = (idx_reg == 2'(head.count - 2'd1));
    assign pop        = take && final_word;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_byte_reg <= head.data[idx_reg];
            last_reg     <= head.last && final_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= !q_stat.empty;
            if (take)
                idx_reg <= final_word ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

[rtl/core/iso2022jp_to_eucjp_converter.sv]
// Top level of the ISO-2022-JP to EUC-JP stream converter.
// Converts a 7-bit JIS byte stream to EUC-JP, one input word per handshake.
// Each accepted word yields zero to three output words: ASCII passes through,
// kanji gets bit 7 set, half-width kana is prefixed with 0x8e and auxiliary
// kanji with 0x8f; a NUL word ends the string, flushes any half-parsed escape
// bytes and comes out as NUL with last high. Rate: one input word per cycle
// as long as each word makes at most one output word and out_stall stays
// low; a word that expands to two or three output words holds the single
// output register for each of them in turn, and the input stalls only once
// the four-entry command queue between the front end and the output
// sequencer has filled. An accepted word passes through the command queue
// and the output register. Escape handling and mode tracking live in the
// front end, which decides a whole word combinationally; the back end
// emits one word per cycle while out_stall is low.
module iso2022jp_to_eucjp_converter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last
);
    import i2e_pkg::*;

    `include "iso2022jp_to_eucjp_converter_assert.svh"

    cmd_t    push_cmd;
    cmd_t    head_cmd;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    // front end: classification and state
    i2e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_stat   (q_stat),
        .push     (push),
        .cmd      (push_cmd)
    );

    // decoupling queue
    i2e_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd_in (push_cmd),
        .pop    (pop),
        .head   (head_cmd),
        .q_stat (q_stat)
    );

    // back end: output sequencer with its own output register
    i2e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

    `I2E_ASSERT_IMP(a_no_push_full, push, !q_stat.full)
    `I2E_ASSERT_IMP(a_no_pop_empty, pop, !q_stat.empty)
    `I2E_ASSERT_IMP(a_last_is_nul, out_valid && last, out_byte == CH_NUL)
    `I2E_ASSERT_NXT(a_queue_drain, pop && !push && !q_stat.full, !q_stat.full)

endmodule

[sim/testbench.sv]
// Self-checking testbench for the ISO-2022-JP to EUC-JP stream converter.
//
// What is checked:
//   Every EUC-JP word that leaves the converter is compared, data and last
//   flag alike, with the oldest word still due, typed in or taken from a
//   cycle-free model of the converter that runs alongside it. A word
//   arriving with nothing due, a wrong field, or a hang all fail the run.
//
// Stimulus:
//   A short directed table comes first. It covers the byte extremes, three
//   escape sequences, SO/SI, a kanji trail byte that looks like ESC, two
//   broken escapes, and a NUL that has to flush held escape bytes.
//   Rows with an obvious result carry it typed in. The other rows go to the
//   model. The random part is built from well-formed pieces (escapes, text
//   runs, SO/SI, end of string) with broken escapes and raw noise mixed in.
//
// Flow control:
//   The sender leaves random gaps, mostly short with a few long ones, and
//   sends bursts with no gaps. The receiver stalls the same way. Once, the
//   receiver holds off long enough for the command queue to fill and push
//   back on the input. Once, the sender pauses until the converter has
//   drained.
module testbench;
    import i2e_pkg::*;

    localparam int DIRECTED_N  = 26;
    localparam int RANDOM_N    = 290;
    localparam int PAUSE_AT    = 180;   // word index where the sender drains the pipe
    localparam int HOLD_START  = 400;   // receiver cycle where the long hold-off begins
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 10;    // wait after the last due word before the verdict
    localparam int CALM_LIMIT  = 2000;  // cycles with no handshake on either side
    localparam int SHOW_MAX    = 10;

    // one EUC-JP output word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } euc_word_t;

    // one JIS input word, with an optional typed-in result (zero or one word)
    typedef struct packed {
        logic [7:0] jis;
        logic       typed;
        logic [1:0] n_typed;
        logic [7:0] typed_data;
        logic       typed_last;
    } jis_row_t;

    // Directed table. typed = 1: the result column is the expectation.
    // typed = 0: the result comes from the model.
    localparam jis_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{8'h41,      1'b1, 2'd1, 8'h41,  1'b0},  // plain ASCII out of reset
        '{8'hff,      1'b1, 2'd1, 8'hff,  1'b0},  // bit 7 set passes in ASCII
        '{CH_NUL,     1'b1, 2'd1, CH_NUL, 1'b1},  // end of string
        '{CH_ESC,     1'b1, 2'd0, 8'h00,  1'b0},  // ESC $ B: kanji, nothing out
        '{CH_DOLLAR,  1'b1, 2'd0, 8'h00,  1'b0},
        '{CH_B,       1'b1, 2'd0, 8'h00,  1'b0},
        '{8'h30,      1'b0, 2'd0, 8'h00,  1'b0},  // kanji lead
        '{CH_ESC,     1'b0, 2'd0, 8'h00,  1'b0},  // ESC taken as trail byte
        '{CH_SO,      1'b0, 2'd0, 8'h00,  1'b0},  // SO from kanji mode
        '{8'h80,      1'b0, 2'd0, 8'h00,  1'b0},  // kana, high bit already set
        '{CH_ESC,     1'b0, 2'd0, 8'h00,  1'b0},  // ESC $ ( D: auxiliary kanji
        '{CH_DOLLAR,  1'b0, 2'd0, 8'h00,  1'b0},
        '{CH_LPAREN,  1'b0, 2'd0, 8'h00,  1'b0},
        '{CH_D,       1'b0, 2'd0, 8'h00,  1'b0},
        '{8'h7f,      1'b0, 2'd0, 8'h00,  1'b0},  // SS3 plus aux lead byte
        '{8'h21,      1'b0, 2'd0, 8'h00,  1'b0},  // aux trail byte
        '{CH_ESC,     1'b0, 2'd0, 8'h00,  1'b0},  // ESC $ ( broken by SI
        '{CH_DOLLAR,  1'b0, 2'd0, 8'h00,  1'b0},
        '{CH_LPAREN,  1'b0, 2'd0, 8'h00,  1'b0},
        '{CH_SI,      1'b0, 2'd0, 8'h00,  1'b0},
        '{CH_ESC,     1'b0, 2'd0, 8'h00,  1'b0},  // ESC ( broken by NUL
        '{CH_LPAREN,  1'b0, 2'd0, 8'h00,  1'b0},
        '{CH_NUL,     1'b0, 2'd0, 8'h00,  1'b0},
        '{CH_ESC,     1'b0, 2'd0, 8'h00,  1'b0},  // ESC ( I: kana
        '{CH_LPAREN,  1'b0, 2'd0, 8'h00,  1'b0},
        '{CH_I,       1'b0, 2'd0, 8'h00,  1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last;

    iso2022jp_to_eucjp_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

    // model state
    mode_t      jis_mode;
    esc_t       jis_esc;
    logic       trail_pending;

    jis_row_t   jis_items [$];
    euc_word_t  due_words [$];
    int         mismatches;
    int         calm_cycles;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cycle-free model: one JIS byte in, zero to three EUC-JP words out.
    function automatic int jis_to_euc(input logic [7:0] b, output euc_word_t res [3]);
        int   n;
        esc_t st;
        logic matched;
        n = 0;
        st = jis_esc;
        if (st != ESC_IDLE) begin
            jis_esc = ESC_IDLE;
            matched = 1'b1;
            if (st == ESC_SEEN && b == CH_DOLLAR)
                jis_esc = ESC_DOLLAR;
            else if (st == ESC_SEEN && b == CH_LPAREN)
                jis_esc = ESC_PAREN;
            else if (st == ESC_DOLLAR && (b == CH_AT || b == CH_B))
                jis_mode = MODE_KANJI;
            else if (st == ESC_DOLLAR && b == CH_LPAREN)
                jis_esc = ESC_DPAREN;
            else if (st == ESC_DPAREN && b == CH_D)
                jis_mode = MODE_AUX;
            else if (st == ESC_PAREN && (b == CH_B || b == CH_J))
                jis_mode = MODE_ASCII;
            else if (st == ESC_PAREN && b == CH_I)
                jis_mode = MODE_KANA;
            else
                matched = 1'b0;
            if (matched)
                return 0;
            // broken escape: drop ESC, send the held bytes, redo b as ASCII
            jis_mode = MODE_ASCII;
            if (st == ESC_DOLLAR || st == ESC_DPAREN)
            begin
                res[n] = {CH_DOLLAR, 1'b0};
                n++;
            end
            if (st == ESC_DPAREN || st == ESC_PAREN)
            begin
                res[n] = {CH_LPAREN, 1'b0};
                n++;
            end
        end
        if (b == CH_NUL)
        begin
            res[n] = {CH_NUL, 1'b1};
            n++;
            jis_mode = MODE_ASCII;
            trail_pending = 1'b0;
            return n;
        end
        if (trail_pending)
        begin
            res[n] = {b | HIGH_BIT, 1'b0};
            n++;
            trail_pending = 1'b0;
            return n;
        end
        if (b == CH_ESC)
        begin
            jis_esc = ESC_SEEN;
            return n;
        end
        if (b == CH_SO)
        begin
            jis_mode = MODE_KANA;
            return n;
        end
        if (b == CH_SI)
        begin
            jis_mode = MODE_ASCII;
            return n;
        end
        case (jis_mode)
            MODE_ASCII:
            begin
                res[n] = {b, 1'b0};
                n++;
            end
            MODE_KANJI:
            begin
                res[n] = {b | HIGH_BIT, 1'b0};
                n++;
                trail_pending = 1'b1;
            end
            MODE_AUX:
            begin
                res[n] = {SS3, 1'b0};
                res[n + 1] = {b | HIGH_BIT, 1'b0};
                n += 2;
                trail_pending = 1'b1;
            end
            default:
            begin
                res[n] = {SS2, 1'b0};
                res[n + 1] = {b | HIGH_BIT, 1'b0};
                n += 2;
            end
        endcase
        return n;
    endfunction

    task automatic note_mismatch(input string what, input euc_word_t want,
                                 input euc_word_t got);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("mismatch at %0t: %s: expected data %h last %b, got data %h last %b",
                     $realtime, what, want.data, want.last, got.data, got.last);
    endtask

    // Stimulus build: well-formed pieces with random content, some noise.
    task automatic build_random_items();
        int         r;
        int         k;
        int         run;
        logic [7:0] seq [$];
        while (jis_items.size() < DIRECTED_N + RANDOM_N)
        begin
            seq.delete();
            r = $urandom_range(0, 99);
            if (r < 22)
            begin
                // one of the six recognized escapes
                k = $urandom_range(0, 5);
                seq.push_back(CH_ESC);
                case (k)
                    0: seq = '{CH_ESC, CH_DOLLAR, CH_AT};
                    1: seq = '{CH_ESC, CH_DOLLAR, CH_B};
                    2: seq = '{CH_ESC, CH_DOLLAR, CH_LPAREN, CH_D};
                    3: seq = '{CH_ESC, CH_LPAREN, CH_B};
                    4: seq = '{CH_ESC, CH_LPAREN, CH_J};
                    default: seq = '{CH_ESC, CH_LPAREN, CH_I};
                endcase
            end
            else if (r < 30)
                seq.push_back($urandom_range(0, 1) ? CH_SO : CH_SI);
            else if (r < 65)
            begin
                // text run; odd lengths leave a kanji trail byte for what follows
                run = $urandom_range(1, 8);
                repeat (run)
                    seq.push_back(($urandom_range(0, 99) < 85) ? 8'($urandom_range(8'h21, 8'h7e))
                                                               : 8'($urandom_range(1, 255)));
            end
            else if (r < 75)
            begin
                // escape broken after ESC, ESC $, ESC $ ( or ESC (
                seq.push_back(CH_ESC);
                case ($urandom_range(0, 3))
                    1: seq.push_back(CH_DOLLAR);
                    2:
                    begin
                        seq.push_back(CH_DOLLAR);
                        seq.push_back(CH_LPAREN);
                    end
                    3: seq.push_back(CH_LPAREN);
                    default: ;
                endcase
                case ($urandom_range(0, 4))
                    0: seq.push_back(CH_ESC);
                    1: seq.push_back(CH_NUL);
                    2: seq.push_back(CH_SO);
                    default: seq.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            else if (r < 83)
                seq.push_back(CH_NUL);
            else
                seq.push_back(8'($urandom_range(0, 255)));
            foreach (seq[i])
                jis_items.push_back('{seq[i], 1'b0, 2'd0, 8'h00, 1'b0});
        end
    endtask

    // Sender side, then the end of the run.
    initial begin
        euc_word_t res [3];
        int        n;
        int        gap;
        int        burst_left;
        jis_row_t  row;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_byte   <= 8'h00;
        mismatches = 0;
        burst_left = 0;
        jis_mode = MODE_ASCII;
        jis_esc = ESC_IDLE;
        trail_pending = 1'b0;
        foreach (DIRECTED_ROWS[i])
            jis_items.push_back(DIRECTED_ROWS[i]);
        build_random_items();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (jis_items[k])
        begin
            row = jis_items[k];
            // gap length: mostly none or short, a few long, bursts with none
            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:49]:  gap = 0;
                    [50:79]: gap = $urandom_range(1, 3);
                    [80:91]: gap = $urandom_range(4, 8);
                    [92:95]: gap = $urandom_range(10, 30);
                    default:
                    begin
                        gap = 0;
                        burst_left = $urandom_range(10, 30);
                    end
                endcase
            end
            // once, let the converter drain completely before going on
            if (k == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (due_words.size() != 0)
                    @(posedge clk);
            end
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= row.jis;
            do
                @(posedge clk);
            while (in_stall);
            // accepted at this edge
            n = jis_to_euc(row.jis, res);
            if (row.typed)
            begin
                if (row.n_typed != 0)
                    due_words.push_back({row.typed_data, row.typed_last});
            end
            else
            begin
                for (int j = 0; j < n; j++)
                    due_words.push_back(res[j]);
            end
        end
        in_valid <= 1'b0;

        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && due_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver side: random stalls, free-running stretches, one long hold-off.
    initial begin
        int rx_cycle;
        int hold_left;
        int free_left;
        out_stall <= 1'b0;
        rx_cycle = 0;
        hold_left = 0;
        free_left = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle == HOLD_START)
                hold_left = HOLD_CYCLES;   // fills the command queue, input must stall
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (free_left > 0)
            begin
                out_stall <= 1'b0;
                free_left--;
            end
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:59]:  out_stall <= 1'b0;
                    [60:84]:
                    begin
                        out_stall <= 1'b1;
                        hold_left = $urandom_range(0, 2);
                    end
                    [85:94]:
                    begin
                        out_stall <= 1'b1;
                        hold_left = $urandom_range(3, 7);
                    end
                    [95:96]:
                    begin
                        out_stall <= 1'b1;
                        hold_left = $urandom_range(10, 30);
                    end
                    default:
                    begin
                        out_stall <= 1'b0;
                        free_left = $urandom_range(15, 40);
                    end
                endcase
            end
        end
    end

    // Output check against the oldest word due.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_words.size() == 0)
                note_mismatch("word with none due", '0, {out_byte, last});
            else
            begin
                if (out_byte !== due_words[0].data || last !== due_words[0].last)
                    note_mismatch("wrong word", due_words[0], {out_byte, last});
                void'(due_words.pop_front());
            end
        end
    end

    // Watchdog: any handshake resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            calm_cycles <= 0;
        else if (calm_cycles >= CALM_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", CALM_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            calm_cycles <= calm_cycles + 1;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/i2e_pkg.sv
rtl/core/i2e_front.sv
rtl/core/i2e_queue.sv
rtl/core/i2e_back.sv
rtl/core/iso2022jp_to_eucjp_converter.sv
sim/testbench.sv
